[rtl/core/scp_pkg.sv]
`timescale 1ns / 1ps

package scp_pkg;

    // Fixed widths of the fields on the ports
    localparam int FIELD_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_X = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_Y = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_X   = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_Y   = CFG_INDEX_WIDTH'(3);

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] vertex_x;
        logic signed [FIELD_WIDTH-1:0] vertex_y;
        logic                          last_vertex;
    } t_vertex;

    typedef struct packed {
        logic                   polygon_crossed;
        logic [FIELD_WIDTH-1:0] crossed_total;
    } t_result;

endpackage

[rtl/core/segment_polygon_crossing_counter.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------
// vertex   | in        | i_in_valid / o_in_ready    | i_vertex  (scp_pkg::t_vertex)
// result   | out       | o_out_valid / i_out_ready  | o_result  (scp_pkg::t_result)
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One vertex per cycle while the input stage is not held. In the input stage both
// edge tests (forward edge and closing edge) run in parallel; the result of a
// last vertex is registered in the output register as it leaves the stage.
// Reset is synchronous, active low: sight segment at the origin, counter zero,
// waiting for the first vertex of a polygon.
// A last vertex waits in the input stage while the output register holds an
// untaken result; o_in_ready drops only then. Config writes are always taken.
module segment_polygon_crossing_counter #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  scp_pkg::t_vertex                      i_vertex,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output scp_pkg::t_result                      o_result,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [scp_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [scp_pkg::FIELD_WIDTH-1:0]       i_cfg_data
);

    localparam int FW = scp_pkg::FIELD_WIDTH;

    // sight segment
    logic signed [COORD_WIDTH-1:0] r_sx, r_sy, r_ex, r_ey;

    // polygon tracking at the accept side
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y;
    logic                          r_await;

    // input stage
    logic                          r_s1_valid;
    logic signed [COORD_WIDTH-1:0] r_s1_cur_x, r_s1_cur_y;
    logic signed [COORD_WIDTH-1:0] r_s1_prev_x, r_s1_prev_y;
    logic signed [COORD_WIDTH-1:0] r_s1_first_x, r_s1_first_y;
    logic                          r_s1_is_first;
    logic                          r_s1_last;

    // accumulation and output
    logic                          r_hit;
    logic [COUNT_WIDTH-1:0]        r_count;
    logic [COUNT_WIDTH-1:0]        n_count;
    logic                          r_out_valid;
    scp_pkg::t_result              r_out;

    logic signed [COORD_WIDTH-1:0] in_x, in_y;
    logic in_go, s1_go, out_free;
    logic fwd_hit, close_hit, hit_base, crossed;

    assign in_x = $signed(COORD_WIDTH'(i_vertex.vertex_x));
    assign in_y = $signed(COORD_WIDTH'(i_vertex.vertex_y));

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_go      = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    scp_edge_test #(.COORD_WIDTH(COORD_WIDTH)) u_fwd_edge (
        .i_ax (r_s1_prev_x), .i_ay (r_s1_prev_y),
        .i_bx (r_s1_cur_x),  .i_by (r_s1_cur_y),
        .i_sx (r_sx), .i_sy (r_sy), .i_ex (r_ex), .i_ey (r_ey),
        .o_hit(fwd_hit)
    );

    scp_edge_test #(.COORD_WIDTH(COORD_WIDTH)) u_close_edge (
        .i_ax (r_s1_cur_x),   .i_ay (r_s1_cur_y),
        .i_bx (r_s1_first_x), .i_by (r_s1_first_y),
        .i_sx (r_sx), .i_sy (r_sy), .i_ex (r_ex), .i_ey (r_ey),
        .o_hit(close_hit)
    );

    always_comb begin
        // the first vertex of a polygon has no forward edge
        hit_base = r_s1_is_first ? 1'b0 : (r_hit || fwd_hit);
        crossed  = hit_base || close_hit;
        n_count  = r_count;
        if (crossed && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                scp_pkg::REG_START_X: r_sx <= $signed(COORD_WIDTH'(i_cfg_data));
                scp_pkg::REG_START_Y: r_sy <= $signed(COORD_WIDTH'(i_cfg_data));
                scp_pkg::REG_END_X:   r_ex <= $signed(COORD_WIDTH'(i_cfg_data));
                scp_pkg::REG_END_Y:   r_ey <= $signed(COORD_WIDTH'(i_cfg_data));
                default: ;
            endcase
        end
    end

    // accept side: capture vertex with its neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await    <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_go) begin
                r_await    <= i_vertex.last_vertex;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_prev_x      <= in_x;
            r_prev_y      <= in_y;
            r_s1_cur_x    <= in_x;
            r_s1_cur_y    <= in_y;
            r_s1_prev_x   <= r_prev_x;
            r_s1_prev_y   <= r_prev_y;
            r_s1_is_first <= r_await;
            r_s1_last     <= i_vertex.last_vertex;
            if (r_await) begin
                r_first_x    <= in_x;
                r_first_y    <= in_y;
                r_s1_first_x <= in_x;
                r_s1_first_y <= in_y;
            end else begin
                r_s1_first_x <= r_first_x;
                r_s1_first_y <= r_first_y;
            end
        end
    end

    // result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_hit <= r_s1_last ? 1'b0 : hit_base;
            end
            if (s1_go && r_s1_last) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out.polygon_crossed <= crossed;
            r_out.crossed_total   <= FW'(n_count);
        end
    end

    // a new result only ever comes from a last vertex leaving the input stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result without a last vertex");

    // the crossed counter never goes backward
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("crossed count decreased");

    // a full input stage is only refilled in the cycle it drains
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && r_s1_valid) |-> s1_go)
        else $error("input stage overwritten");

    // after a last vertex the next transfer starts a new polygon
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && i_vertex.last_vertex) |=> r_await)
        else $error("polygon start not armed after last vertex");

endmodule

[rtl/core/scp_edge_test.sv]
`timescale 1ns / 1ps

// Closed segment A-B against the sight segment S-E with exact cross products.
// Endpoint touch and collinear overlap both count as a hit.
module scp_edge_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_sx,
    input  logic signed [COORD_WIDTH-1:0] i_sy,
    input  logic signed [COORD_WIDTH-1:0] i_ex,
    input  logic signed [COORD_WIDTH-1:0] i_ey,
    output logic                          o_hit
);

    // Sign of cross((b-a),(c-a)) as {positive, negative}
    function automatic logic [1:0] orient_sign(
        input logic signed [COORD_WIDTH-1:0] ax,
        input logic signed [COORD_WIDTH-1:0] ay,
        input logic signed [COORD_WIDTH-1:0] bx,
        input logic signed [COORD_WIDTH-1:0] by,
        input logic signed [COORD_WIDTH-1:0] cx,
        input logic signed [COORD_WIDTH-1:0] cy
    );
        logic signed [COORD_WIDTH:0]     dbx;
        logic signed [COORD_WIDTH:0]     dby;
        logic signed [COORD_WIDTH:0]     dcx;
        logic signed [COORD_WIDTH:0]     dcy;
        logic signed [2*COORD_WIDTH+1:0] lhs;
        logic signed [2*COORD_WIDTH+1:0] rhs;
        dbx = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
        dby = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
        dcx = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
        dcy = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};
        lhs = dbx * dcy;
        rhs = dby * dcx;
        return {lhs > rhs, lhs < rhs};
    endfunction

    logic [1:0] o1, o2, o3, o4;
    logic       collinear;
    logic       range_ok;
    logic       straddle_s, straddle_e;
    logic signed [COORD_WIDTH-1:0] s_lo_x, s_hi_x, s_lo_y, s_hi_y;
    logic signed [COORD_WIDTH-1:0] e_lo_x, e_hi_x, e_lo_y, e_hi_y;

    always_comb begin
        o1 = orient_sign(i_sx, i_sy, i_ex, i_ey, i_ax, i_ay);
        o2 = orient_sign(i_sx, i_sy, i_ex, i_ey, i_bx, i_by);
        o3 = orient_sign(i_ax, i_ay, i_bx, i_by, i_sx, i_sy);
        o4 = orient_sign(i_ax, i_ay, i_bx, i_by, i_ex, i_ey);

        collinear = (o1 == 2'b00) && (o2 == 2'b00) && (o3 == 2'b00) && (o4 == 2'b00);

        s_lo_x = (i_sx < i_ex) ? i_sx : i_ex;
        s_hi_x = (i_sx > i_ex) ? i_sx : i_ex;
        s_lo_y = (i_sy < i_ey) ? i_sy : i_ey;
        s_hi_y = (i_sy > i_ey) ? i_sy : i_ey;
        e_lo_x = (i_ax < i_bx) ? i_ax : i_bx;
        e_hi_x = (i_ax > i_bx) ? i_ax : i_bx;
        e_lo_y = (i_ay < i_by) ? i_ay : i_by;
        e_hi_y = (i_ay > i_by) ? i_ay : i_by;

        range_ok = (s_hi_x >= e_lo_x) && (s_lo_x <= e_hi_x) &&
                   (s_hi_y >= e_lo_y) && (s_lo_y <= e_hi_y);

        // product of signs <= 0: not both strictly the same side
        straddle_s = !((o1[1] && o2[1]) || (o1[0] && o2[0]));
        straddle_e = !((o3[1] && o4[1]) || (o3[0] && o4[0]));

        o_hit = collinear ? range_ok : (straddle_s && straddle_e);
    end

endmodule

[bench/segment_polygon_crossing_counter_test.sv]
`timescale 1ns / 1ps

module segment_polygon_crossing_counter_test;

    localparam int FW = scp_pkg::FIELD_WIDTH;
    localparam int IW = scp_pkg::CFG_INDEX_WIDTH;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 6;
    localparam int TIMEOUT_NS       = 20_000_000;
    localparam int MISMATCH_REPORTS = 50;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_VERTICES   = 250;
    localparam int SINGLE_POLYGONS  = 20;

    localparam logic [FW-1:0] COUNT_MAX    = '1;
    localparam logic [IW-1:0] REG_SPARE_LO = scp_pkg::REG_END_Y + 1'b1;
    localparam logic [IW-1:0] REG_SPARE_HI = '1;
    localparam int COORD_EXTREMES [4] = '{-32768, 32767, 0, -1};

    typedef enum logic [1:0] {ROW_VERTEX, ROW_REG} t_row_kind;
    typedef enum {SIGHT_WIDE, SIGHT_SHORT, SIGHT_POINT, SIGHT_AXIS, SIGHT_CORNER} t_sight_kind;
    typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_MOSTLY, DRAIN_CYCLIC} t_drain_mode;

    // a/b: vertex x/y, or register data in a
    typedef struct packed {
        t_row_kind     kind;
        logic [IW-1:0] idx;
        int            a;
        int            b;
        logic          last;
        logic          pinned;
        logic          exp_hit;
        int            exp_total;
    } t_row;

    localparam int DIRECTED_ROWS = 36;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // sight is a point at the origin after reset
        '{ROW_VERTEX, scp_pkg::REG_START_X,      0,      0, 1'b1, 1'b1, 1'b1, 1},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      5,      5, 1'b1, 1'b1, 1'b0, 1},
        // full-range diagonal
        '{ROW_REG,    scp_pkg::REG_START_X, -32768,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_START_Y, -32768,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_X,    32767,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_Y,    32767,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X, -32768,  32767, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,  32767, -32768, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      0,    100, 1'b1, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,    100,   -100, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,    200,   -150, 1'b1, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,  32767,  32767, 1'b1, 1'b0, 1'b0, 0},
        // horizontal sight: collinear overlap, then collinear but disjoint
        '{ROW_REG,    scp_pkg::REG_START_X,    -10,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_START_Y,      0,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_X,       10,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_Y,        0,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      5,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     20,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     20,      5, 1'b1, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     11,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     30,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     30,      7, 1'b1, 1'b0, 1'b0, 0},
        // vertical sight
        '{ROW_REG,    scp_pkg::REG_START_X,      0,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_START_Y,    -10,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_X,        0,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    scp_pkg::REG_END_Y,       10,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      0,     11, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      0,     40, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      3,     40, 1'b1, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,     -1,     -1, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      1,      1, 1'b1, 1'b0, 1'b0, 0},
        // writes to unused indexes must leave the sight alone
        '{ROW_REG,    REG_SPARE_LO,            100,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_REG,    REG_SPARE_HI,             -1,      0, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,      0,      5, 1'b1, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X, -32768, -32768, 1'b0, 1'b0, 1'b0, 0},
        '{ROW_VERTEX, scp_pkg::REG_START_X,  32767,  32767, 1'b1, 1'b0, 1'b0, 0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    scp_pkg::t_vertex i_vertex    = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    scp_pkg::t_result o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IW-1:0]    i_cfg_index = '0;
    logic [FW-1:0]    i_cfg_data  = '0;

    segment_polygon_crossing_counter uut (.*);

    // predictor state
    logic signed [FW-1:0] sight_sx = '0, sight_sy = '0, sight_ex = '0, sight_ey = '0;
    logic signed [FW-1:0] poly_first_x = '0, poly_first_y = '0;
    logic signed [FW-1:0] poly_prev_x = '0, poly_prev_y = '0;
    bit                   poly_open = 1'b0;
    bit                   poly_hit = 1'b0;
    logic [FW-1:0]        crossed_count = '0;

    scp_pkg::t_result expected_tallies [$];
    int               mismatches = 0;
    int               burst_left = 0;

    t_drain_mode drain_mode = DRAIN_FREE;
    int          drain_left = 0;
    int          drain_tick = 0;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int turn_sign(input longint ax, ay, bx, by, cx, cy);
        longint l, r;
        l = (bx - ax) * (cy - ay);
        r = (by - ay) * (cx - ax);
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic longint lesser(input longint p, q);
        return (p < q) ? p : q;
    endfunction

    function automatic longint greater(input longint p, q);
        return (p > q) ? p : q;
    endfunction

    function automatic bit edge_meets_sight(input longint ax, ay, bx, by);
        longint sx, sy, ex, ey;
        int o1, o2, o3, o4;
        sx = sight_sx;
        sy = sight_sy;
        ex = sight_ex;
        ey = sight_ey;
        o1 = turn_sign(sx, sy, ex, ey, ax, ay);
        o2 = turn_sign(sx, sy, ex, ey, bx, by);
        o3 = turn_sign(ax, ay, bx, by, sx, sy);
        o4 = turn_sign(ax, ay, bx, by, ex, ey);
        // all on one line: closed box overlap in both axes
        if (o1 == 0 && o2 == 0 && o3 == 0 && o4 == 0)
            return greater(sx, ex) >= lesser(ax, bx) && lesser(sx, ex) <= greater(ax, bx) &&
                   greater(sy, ey) >= lesser(ay, by) && lesser(sy, ey) <= greater(ay, by);
        return (o1 * o2 <= 0) && (o3 * o4 <= 0);
    endfunction

    function automatic bit predict_vertex(input scp_pkg::t_vertex v,
                                          output scp_pkg::t_result res);
        longint vx, vy;
        bit     crossed;
        vx  = longint'($signed(v.vertex_x));
        vy  = longint'($signed(v.vertex_y));
        res = '0;
        if (!poly_open) begin
            poly_first_x = v.vertex_x;
            poly_first_y = v.vertex_y;
            poly_hit     = 1'b0;
            poly_open    = 1'b1;
        end else if (edge_meets_sight(poly_prev_x, poly_prev_y, vx, vy)) begin
            poly_hit = 1'b1;
        end
        poly_prev_x = v.vertex_x;
        poly_prev_y = v.vertex_y;
        if (!v.last_vertex)
            return 1'b0;
        // closing edge back to the first vertex
        crossed = poly_hit || edge_meets_sight(vx, vy, poly_first_x, poly_first_y);
        if (crossed && crossed_count != COUNT_MAX)
            crossed_count = crossed_count + 1'b1;
        res.polygon_crossed = crossed;
        res.crossed_total   = crossed_count;
        poly_open = 1'b0;
        poly_hit  = 1'b0;
        return 1'b1;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic await_all_tallies();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_tallies.size() != 0)
            @(posedge i_clk);
        // a non-last vertex may still sit in the input stage
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input int data);
        await_all_tallies();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= FW'(data);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            scp_pkg::REG_START_X: sight_sx = FW'(data);
            scp_pkg::REG_START_Y: sight_sy = FW'(data);
            scp_pkg::REG_END_X:   sight_ex = FW'(data);
            scp_pkg::REG_END_Y:   sight_ey = FW'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_vertex(input scp_pkg::t_vertex v, input bit pinned,
                               input scp_pkg::t_result pinned_res);
        scp_pkg::t_result res;
        int               gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(32, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_vertex   <= v;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (predict_vertex(v, res))
            expected_tallies.push_back(pinned ? pinned_res : res);
    endtask

    task automatic aim_sight(input t_sight_kind kind);
        int c [4];
        int bx, by, d;
        bx = int'($urandom_range(400)) - 200;
        by = int'($urandom_range(400)) - 200;
        d  = int'($urandom_range(200)) - 100;
        case (kind)
            SIGHT_WIDE:  foreach (c[k]) c[k] = any_coord();
            SIGHT_SHORT: c = '{bx, by, bx + d, by + int'($urandom_range(200)) - 100};
            SIGHT_POINT: c = '{bx, by, bx, by};
            SIGHT_AXIS: begin
                if ($urandom_range(1) == 1)
                    c = '{bx, by, bx, by + d};
                else
                    c = '{bx, by, bx + d, by};
            end
            default: foreach (c[k]) c[k] = ($urandom_range(1) == 1) ? 32767 : -32768;
        endcase
        write_reg(scp_pkg::REG_START_X, c[0]);
        write_reg(scp_pkg::REG_START_Y, c[1]);
        write_reg(scp_pkg::REG_END_X, c[2]);
        write_reg(scp_pkg::REG_END_Y, c[3]);
        if ($urandom_range(1) == 1)
            write_reg(IW'(REG_SPARE_LO +
                      $urandom_range(int'(REG_SPARE_HI - REG_SPARE_LO))), any_coord());
    endtask

    // vertices biased toward the sight so edges touch, cross and run along it
    task automatic pick_point(output int x, output int y);
        int r, sx, sy, ex, ey;
        sx = sight_sx;
        sy = sight_sy;
        ex = sight_ex;
        ey = sight_ey;
        r  = $urandom_range(99);
        if (r < 15) begin
            case ($urandom_range(3))
                0: begin x = sx; y = sy; end
                1: begin x = ex; y = ey; end
                2: begin x = (sx + ex) >>> 1; y = (sy + ey) >>> 1; end
                default: begin x = 2 * ex - sx; y = 2 * ey - sy; end
            endcase
        end else if (r < 45) begin
            x = (($urandom_range(1) == 1) ? sx : ex) + int'($urandom_range(80)) - 40;
            y = (($urandom_range(1) == 1) ? sy : ey) + int'($urandom_range(80)) - 40;
        end else if (r < 65) begin
            x = int'($urandom_range(127)) - 64;
            y = int'($urandom_range(127)) - 64;
        end else if (r < 75) begin
            x = COORD_EXTREMES[$urandom_range(3)];
            y = COORD_EXTREMES[$urandom_range(3)];
        end else begin
            x = any_coord();
            y = any_coord();
        end
    endtask

    initial begin
        scp_pkg::t_vertex v;
        scp_pkg::t_result pinned_res;
        int               sent, n, r, x, y;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                write_reg(DIRECTED[i].idx, DIRECTED[i].a);
            end else begin
                v.vertex_x                 = FW'(DIRECTED[i].a);
                v.vertex_y                 = FW'(DIRECTED[i].b);
                v.last_vertex              = DIRECTED[i].last;
                pinned_res.polygon_crossed = DIRECTED[i].exp_hit;
                pinned_res.crossed_total   = FW'(DIRECTED[i].exp_total);
                send_vertex(v, DIRECTED[i].pinned, pinned_res);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            aim_sight(t_sight_kind'(p % 5));
            sent = 0;
            while (sent < PHASE_VERTICES) begin
                r = $urandom_range(99);
                n = (r < 55) ? $urandom_range(4, 1) :
                    (r < 90) ? $urandom_range(10, 5) : $urandom_range(24, 11);
                for (int k = 0; k < n; k++) begin
                    // now and then a zero-length edge
                    if (k == 0 || $urandom_range(19) != 0)
                        pick_point(x, y);
                    v.vertex_x    = FW'(x);
                    v.vertex_y    = FW'(y);
                    v.last_vertex = (k == n - 1);
                    send_vertex(v, 1'b0, '0);
                end
                sent += n;
                if ($urandom_range(39) == 0)
                    await_all_tallies();
            end
        end

        // single-vertex polygons, mostly on the diagonal sight
        write_reg(scp_pkg::REG_START_X, -100);
        write_reg(scp_pkg::REG_START_Y, -100);
        write_reg(scp_pkg::REG_END_X, 100);
        write_reg(scp_pkg::REG_END_Y, 100);
        for (int k = 0; k < SINGLE_POLYGONS; k++) begin
            v.last_vertex = 1'b1;
            if ($urandom_range(15) == 0) begin
                v.vertex_x = FW'(500);
                v.vertex_y = FW'(-500);
            end else begin
                v.vertex_x = '0;
                v.vertex_y = '0;
            end
            send_vertex(v, 1'b0, '0);
        end

        await_all_tallies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_tallies.size() == 0)
            $display("PASS segment_polygon_crossing_counter");
        else
            $display("FAIL segment_polygon_crossing_counter");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL segment_polygon_crossing_counter");
        $finish;
    end

    // result side back-pressure, switching between patterns
    always @(negedge i_clk) begin
        if (drain_left == 0) begin
            drain_mode = t_drain_mode'($urandom_range(3));
            drain_left = $urandom_range(400, 30);
        end
        drain_left--;
        drain_tick++;
        case (drain_mode)
            DRAIN_FREE:   i_out_ready <= 1'b1;
            DRAIN_COIN:   i_out_ready <= 1'($urandom_range(1));
            DRAIN_MOSTLY: i_out_ready <= ($urandom_range(3) != 0);
            default:      i_out_ready <= (drain_tick % 5 < 2);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        scp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tallies.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_REPORTS)
                    $error("result transfer with nothing expected: crossed=%0b total=%0d",
                           o_result.polygon_crossed, o_result.crossed_total);
            end else begin
                want = expected_tallies.pop_front();
                if (o_result.polygon_crossed !== want.polygon_crossed) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_REPORTS)
                        $error("polygon_crossed: expected %0b, got %0b",
                               want.polygon_crossed, o_result.polygon_crossed);
                end
                if (o_result.crossed_total !== want.crossed_total) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_REPORTS)
                        $error("crossed_total: expected %0d, got %0d",
                               want.crossed_total, o_result.crossed_total);
                end
            end
        end
    end

endmodule
